/* rtl/hcbp_pkg.sv */
// package for the code-table bit packer: widths, request codes, sequencer states
// and the control/status structs passed between the top level and the packer
// no dependencies
package hcbp_pkg;

   localparam int SYMBOL_COUNT  = 256;
   localparam int SYM_W         = $clog2(SYMBOL_COUNT);
   localparam int CODE_W        = 16;
   localparam int MAX_CODE_BITS = 16;
   localparam int LEN_W         = 5;
   localparam int BYTE_W        = 8;
   localparam int PENDING_W     = BYTE_W - 1;
   localparam int CNT_W         = 3;
   localparam int PENDING_MAX   = 7;
   localparam int SHAMT_W       = 4;

   // request type codes
   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_ENCODE = 2'd1,
      REQ_FLUSH  = 2'd2
   } req_kind_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SHIFT
   } state_type;

   // packer operations
   typedef enum logic [1:0] {
      PK_NOP,
      PK_LOAD,
      PK_SHIFT,
      PK_FLUSH
   } pk_op_type;

   typedef struct packed {
      pk_op_type          op;
      logic [CODE_W-1:0]  code;
      logic [LEN_W-1:0]   len;
   } pk_ctrl_type;

   typedef struct packed {
      logic last_bit;
      logic active;
   } pk_status_type;

endpackage

/* rtl/huffman_code_bit_packer_top.sv */
// top level of the code-table bit packer: request handshake, sequencer,
// code table and bit-serial packer; depends on hcbp_pkg, hcbp_table, hcbp_packer
//
//   channel   ports                                         flow control
//   request   start, busy, req_type, req_symbol,            taken when start && !busy
//             req_code_word, req_code_length
//   result    rsp_strobe, rsp_out_byte, rsp_last_of_item    one-cycle strobe per byte, no stall
//
// load and flush never raise busy; a flush byte shows in the cycle after the
// request is taken. encode reads the table in the lookup state, loads the packer
// and then shifts out one code bit per shift step, staying busy until the last
// code bit. an encode of a missing or empty entry goes from lookup back to idle
// and emits nothing. reset clears the valid flags of all table entries at once
// and the pending bit count; no clearing pass.
// results cannot be held off, so nothing inside ever waits on the receiver.
module huffman_code_bit_packer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic [hcbp_pkg::SYM_W-1:0]    req_symbol,
   input  logic [hcbp_pkg::CODE_W-1:0]   req_code_word,
   input  logic [hcbp_pkg::LEN_W-1:0]    req_code_length,
   output logic                          rsp_strobe,
   output logic [hcbp_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_last_of_item
);

   hcbp_pkg::state_type     state_ff, state_in;
   hcbp_pkg::pk_ctrl_type   pk_ctrl;
   hcbp_pkg::pk_status_type pk_status;
   logic                    accept;
   logic                    tbl_we;
   logic [hcbp_pkg::CODE_W-1:0] rd_code;
   logic [hcbp_pkg::LEN_W-1:0]  rd_len;
   logic                        rd_valid;

   // request taken only while the sequencer is idle
   assign busy   = (state_ff != hcbp_pkg::ST_IDLE);
   assign accept = start && !busy;
   // table write happens right at the accepting edge
   assign tbl_we = accept && (req_type == hcbp_pkg::REQ_LOAD);

   hcbp_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_we),
      .wr_addr  (req_symbol),
      .wr_code  (req_code_word),
      .wr_len   (req_code_length),
      .rd_addr  (req_symbol),
      .rd_code  (rd_code),
      .rd_len   (rd_len),
      .rd_valid (rd_valid)
   );

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcbp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and packer control
   always_comb begin
      state_in     = state_ff;
      pk_ctrl.op   = hcbp_pkg::PK_NOP;
      pk_ctrl.code = rd_code;
      pk_ctrl.len  = rd_len;
      case (state_ff)
         hcbp_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  hcbp_pkg::REQ_ENCODE: state_in   = hcbp_pkg::ST_LOOKUP;
                  hcbp_pkg::REQ_FLUSH:  pk_ctrl.op = hcbp_pkg::PK_FLUSH;
                  default: begin
                  end
               endcase
            end
         end
         hcbp_pkg::ST_LOOKUP: begin
            // table data for the accepted symbol is registered now
            if (rd_valid && (rd_len != '0)) begin
               pk_ctrl.op = hcbp_pkg::PK_LOAD;
               state_in   = hcbp_pkg::ST_SHIFT;
            end else begin
               state_in = hcbp_pkg::ST_IDLE;
            end
         end
         hcbp_pkg::ST_SHIFT: begin
            pk_ctrl.op = hcbp_pkg::PK_SHIFT;
            if (pk_status.last_bit) begin
               state_in = hcbp_pkg::ST_IDLE;
            end
         end
         default: state_in = hcbp_pkg::ST_IDLE;
      endcase
   end

   hcbp_packer u_packer (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (pk_ctrl),
      .status           (pk_status),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_item (rsp_last_of_item)
   );

`ifndef SYNTHESIS
   // a byte only follows a shift step or a flush request
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == hcbp_pkg::ST_SHIFT ||
                           (accept && req_type == hcbp_pkg::REQ_FLUSH)))
      else $error("result byte without a shift step or flush");
   // a non-final byte means more code bits are still being shifted
   a_more_after_nonlast: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_item |-> state_ff == hcbp_pkg::ST_SHIFT)
      else $error("non-final byte with encode already finished");
   // lookup state is never held
   a_lookup_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == hcbp_pkg::ST_LOOKUP |=> state_ff != hcbp_pkg::ST_LOOKUP)
      else $error("lookup state held");
   // shifting always has bits loaded
   a_shift_active: assert property (@(posedge clock) disable iff (reset)
      state_ff == hcbp_pkg::ST_SHIFT |-> pk_status.active)
      else $error("shift state with empty code register");
`endif

endmodule

/* rtl/hcbp_table.sv */
// code table: 256-entry code/length memory with registered read, plus
// per-entry valid flags cleared at reset; depends on hcbp_pkg
module hcbp_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [hcbp_pkg::SYM_W-1:0]   wr_addr,
   input  logic [hcbp_pkg::CODE_W-1:0]  wr_code,
   input  logic [hcbp_pkg::LEN_W-1:0]   wr_len,
   input  logic [hcbp_pkg::SYM_W-1:0]   rd_addr,
   output logic [hcbp_pkg::CODE_W-1:0]  rd_code,
   output logic [hcbp_pkg::LEN_W-1:0]   rd_len,
   output logic                         rd_valid
);

   logic [hcbp_pkg::CODE_W+hcbp_pkg::LEN_W-1:0] mem [hcbp_pkg::SYMBOL_COUNT];
   logic [hcbp_pkg::SYMBOL_COUNT-1:0]          valid_ff;
   logic [hcbp_pkg::CODE_W+hcbp_pkg::LEN_W-1:0] rd_data_ff;
   logic                                       rd_valid_ff;
   logic [hcbp_pkg::LEN_W-1:0]                 sat_len;

   // lengths above the maximum are stored saturated
   assign sat_len = (wr_len > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_BITS)) ?
                    hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_BITS) : wr_len;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_code, sat_len};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_code  = rd_data_ff[hcbp_pkg::CODE_W+hcbp_pkg::LEN_W-1:hcbp_pkg::LEN_W];
   assign rd_len   = rd_data_ff[hcbp_pkg::LEN_W-1:0];
   assign rd_valid = rd_valid_ff;

endmodule

/* rtl/hcbp_packer.sv */
// bit-serial packer: code shift register, 7-bit accumulator and output byte
// register; one code bit per shift step; depends on hcbp_pkg
module hcbp_packer (
   input  logic                          clock,
   input  logic                          reset,
   input  hcbp_pkg::pk_ctrl_type         ctrl,
   output hcbp_pkg::pk_status_type       status,
   output logic                          rsp_strobe,
   output logic [hcbp_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_last_of_item
);

   logic [hcbp_pkg::PENDING_W-1:0] acc_ff, acc_in;
   logic [hcbp_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [hcbp_pkg::CODE_W-1:0]    code_ff, code_in;
   logic [hcbp_pkg::LEN_W-1:0]     left_ff, left_in;
   logic [hcbp_pkg::BYTE_W-1:0]    byte_ff, byte_in;
   logic                           last_ff, last_in;
   logic                           strobe_ff, strobe_in;
   logic                           next_bit;
   logic [hcbp_pkg::SHAMT_W-1:0]   flush_sh;
   logic [hcbp_pkg::BYTE_W-1:0]    flush_byte;

   assign next_bit   = code_ff[0];
   // left-align pending bits, zero fill below
   assign flush_sh   = hcbp_pkg::SHAMT_W'(hcbp_pkg::BYTE_W) - hcbp_pkg::SHAMT_W'(cnt_ff);
   assign flush_byte = {1'b0, acc_ff} << flush_sh;

   always_comb begin
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      code_in   = code_ff;
      left_in   = left_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      strobe_in = 1'b0;
      case (ctrl.op)
         hcbp_pkg::PK_LOAD: begin
            code_in = ctrl.code;
            left_in = ctrl.len;
         end
         hcbp_pkg::PK_SHIFT: begin
            code_in = code_ff >> 1;
            left_in = left_ff - hcbp_pkg::LEN_W'(1);
            if (cnt_ff == hcbp_pkg::CNT_W'(hcbp_pkg::PENDING_MAX)) begin
               strobe_in = 1'b1;
               byte_in   = {acc_ff, next_bit};
               // last byte unless a full byte of code bits still remains
               last_in   = (left_ff <= hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_W));
               acc_in    = '0;
               cnt_in    = '0;
            end else begin
               acc_in = {acc_ff[hcbp_pkg::PENDING_W-2:0], next_bit};
               cnt_in = cnt_ff + hcbp_pkg::CNT_W'(1);
            end
         end
         hcbp_pkg::PK_FLUSH: begin
            strobe_in = 1'b1;
            byte_in   = flush_byte;
            last_in   = 1'b1;
            acc_in    = '0;
            cnt_in    = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         cnt_ff    <= '0;
         left_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         left_ff   <= left_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign status.last_bit = (left_ff == hcbp_pkg::LEN_W'(1));
   assign status.active   = (left_ff != '0);

   assign rsp_strobe       = strobe_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_last_of_item = last_ff;

`ifndef SYNTHESIS
   a_shift_has_bits: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == hcbp_pkg::PK_SHIFT |-> left_ff != '0)
      else $error("shift step with no code bits left");
   a_byte_clears_acc: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> cnt_ff == '0)
      else $error("accumulator not cleared after byte");
`endif

endmodule

/* test/huffman_code_bit_packer_top_tb.sv */
// self-checking testbench for huffman_code_bit_packer_top: directed and random
// load, encode and flush requests checked byte by byte against a behavioral packer
// depends on hcbp_pkg and the rtl of huffman_code_bit_packer_top
module huffman_code_bit_packer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // request code the block must ignore
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // cycle budget for the whole run, far above the slowest legal run
   localparam int CYCLE_LIMIT = 200000;
   // quiet cycles after the last expected byte: longest encode plus margin
   localparam int TAIL_CYCLES = 24;
   localparam int ITEMS_PER_PHASE = 100;

   typedef struct {
      logic [hcbp_pkg::BYTE_W-1:0] value;
      logic                        last;
   } packed_byte_type;

   // behavioral code table plus msb-first packer and the bytes it owes
   class bit_packer_model_type;
      logic [hcbp_pkg::CODE_W-1:0] code_mem [hcbp_pkg::SYMBOL_COUNT];
      logic [hcbp_pkg::LEN_W-1:0]  len_mem [hcbp_pkg::SYMBOL_COUNT];
      bit                          entry_valid [hcbp_pkg::SYMBOL_COUNT];
      logic [hcbp_pkg::BYTE_W-1:0] acc_bits;
      int                          acc_count;
      packed_byte_type             expected_bytes [$];
      int                          errors;

      function new();
         foreach (entry_valid[i]) entry_valid[i] = 1'b0;
         acc_bits = '0;
         acc_count = 0;
         errors = 0;
      endfunction

      // called at the edge that takes a request
      function void accept_request(logic [1:0] kind, logic [hcbp_pkg::SYM_W-1:0] sym,
                                   logic [hcbp_pkg::CODE_W-1:0] word,
                                   logic [hcbp_pkg::LEN_W-1:0] len);
         logic [hcbp_pkg::BYTE_W-1:0] done [2];
         int                          n;
         int                          cl;
         packed_byte_type             item;
         n = 0;
         case (kind)
            hcbp_pkg::REQ_LOAD: begin
               cl = (len > hcbp_pkg::MAX_CODE_BITS) ? hcbp_pkg::MAX_CODE_BITS : len;
               for (int i = 0; i < hcbp_pkg::CODE_W; i++)
                  if (i >= cl) word[i] = 1'b0;
               code_mem[sym] = word;
               len_mem[sym] = hcbp_pkg::LEN_W'(cl);
               entry_valid[sym] = 1'b1;
            end
            hcbp_pkg::REQ_ENCODE: begin
               if (entry_valid[sym]) begin
                  cl = len_mem[sym];
                  for (int i = 0; i < cl; i++) begin
                     acc_bits = {acc_bits[hcbp_pkg::BYTE_W-2:0], code_mem[sym][i]};
                     acc_count++;
                     if (acc_count > hcbp_pkg::PENDING_MAX) begin
                        done[n] = acc_bits;
                        n++;
                        acc_bits = '0;
                        acc_count = 0;
                     end
                  end
               end
            end
            hcbp_pkg::REQ_FLUSH: begin
               done[0] = acc_bits << (hcbp_pkg::BYTE_W - acc_count);
               n = 1;
               acc_bits = '0;
               acc_count = 0;
            end
            default: ;
         endcase
         for (int k = 0; k < n; k++) begin
            item.value = done[k];
            item.last = (k == n - 1);
            expected_bytes.push_back(item);
         end
      endfunction

      function void check_byte(logic [hcbp_pkg::BYTE_W-1:0] value, logic last);
         packed_byte_type want;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte out_byte=%02h last_of_item=%b",
                     $time, value, last);
            errors++;
            return;
         end
         want = expected_bytes.pop_front();
         if (value !== want.value) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.value, value);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last_of_item expected %b actual %b", $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [1:0]                    req_type;
   logic [hcbp_pkg::SYM_W-1:0]    req_symbol;
   logic [hcbp_pkg::CODE_W-1:0]   req_code_word;
   logic [hcbp_pkg::LEN_W-1:0]    req_code_length;
   logic                          rsp_strobe;
   logic [hcbp_pkg::BYTE_W-1:0]   rsp_out_byte;
   logic                          rsp_last_of_item;

   bit_packer_model_type          packer;
   int                            idle_pct;
   int                            cycle_count;
   logic [hcbp_pkg::SYM_W-1:0]    loaded_syms [$];

   huffman_code_bit_packer_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_symbol       (req_symbol),
      .req_code_word    (req_code_word),
      .req_code_length  (req_code_length),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_item (rsp_last_of_item)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // results cannot be stalled, so every strobe is checked on the edge it ends
   always @(posedge clock) begin
      if (!reset && rsp_strobe) packer.check_byte(rsp_out_byte, rsp_last_of_item);
   end

   // watchdog: a hung handshake or a missing byte ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // present one request, with random sender idling before it, and hold it
   // until the edge where start is high and busy is low
   task automatic send_request(input logic [1:0] kind,
                               input logic [hcbp_pkg::SYM_W-1:0] sym,
                               input logic [hcbp_pkg::CODE_W-1:0] word,
                               input logic [hcbp_pkg::LEN_W-1:0] len);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_symbol <= sym;
      req_code_word <= word;
      req_code_length <= len;
      @(posedge clock);
      while (busy) @(posedge clock);
      packer.accept_request(kind, sym, word, len);
      if (kind == hcbp_pkg::REQ_LOAD) loaded_syms.push_back(sym);
   endtask

   // sender holds off until every owed byte has come out and the block is idle
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (packer.expected_bytes.size() != 0 || busy) @(posedge clock);
   endtask

   // one random request; returns 1 for a load, a flush or an encode of a loaded entry
   task automatic send_random_request(output bit counted);
      int                          r;
      logic [1:0]                  kind;
      logic [hcbp_pkg::SYM_W-1:0]  sym;
      logic [hcbp_pkg::CODE_W-1:0] word;
      logic [hcbp_pkg::LEN_W-1:0]  len;
      r = $urandom_range(99);
      sym = hcbp_pkg::SYM_W'($urandom_range(hcbp_pkg::SYMBOL_COUNT - 1));
      word = hcbp_pkg::CODE_W'($urandom);
      len = hcbp_pkg::LEN_W'($urandom);
      if (r < 22) begin
         kind = hcbp_pkg::REQ_LOAD;
         // mostly legal lengths, sometimes oversized ones that saturate
         if ($urandom_range(99) < 85)
            len = hcbp_pkg::LEN_W'($urandom_range(hcbp_pkg::MAX_CODE_BITS));
      end else if (r < 82) begin
         kind = hcbp_pkg::REQ_ENCODE;
         // mostly symbols that have an entry, the rest random symbols that may hit empty slots
         if (loaded_syms.size() != 0 && $urandom_range(99) < 90)
            sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
      end else if (r < 95) begin
         kind = hcbp_pkg::REQ_FLUSH;
      end else begin
         kind = REQ_UNUSED;
      end
      counted = (kind == hcbp_pkg::REQ_LOAD) || (kind == hcbp_pkg::REQ_FLUSH) ||
                (kind == hcbp_pkg::REQ_ENCODE && packer.entry_valid[sym]);
      send_request(kind, sym, word, len);
   endtask

   initial begin
      int phase_idle [4];
      int done_items;
      bit counted;
      packer = new();
      cycle_count = 0;
      idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_type = hcbp_pkg::REQ_LOAD;
      req_symbol = '0;
      req_code_word = '0;
      req_code_length = '0;
      phase_idle = '{0, 73, 0, 29};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_request(hcbp_pkg::REQ_FLUSH, 8'h00, 16'h0000, 5'd0);   // nothing pending
      send_request(hcbp_pkg::REQ_ENCODE, 8'h00, 16'hffff, 5'd31); // no entry yet
      send_request(REQ_UNUSED, 8'hff, 16'hffff, 5'd31);           // unused type, ignored
      send_request(hcbp_pkg::REQ_LOAD, 8'h00, 16'hffff, 5'd0);    // zero-length entry
      send_request(hcbp_pkg::REQ_ENCODE, 8'h00, 16'h0000, 5'd0);
      send_request(hcbp_pkg::REQ_LOAD, 8'hff, 16'hffff, 5'd31);   // length saturates to 16
      send_request(hcbp_pkg::REQ_ENCODE, 8'hff, 16'h0000, 5'd0);  // two bytes in one encode
      send_request(hcbp_pkg::REQ_LOAD, 8'h01, 16'hfff5, 5'd3);    // upper word bits dropped
      send_request(hcbp_pkg::REQ_ENCODE, 8'h01, 16'h0000, 5'd0);
      send_request(hcbp_pkg::REQ_FLUSH, 8'hff, 16'hffff, 5'd31);  // partial byte left-aligned
      send_request(hcbp_pkg::REQ_LOAD, 8'h02, 16'h0000, 5'd16);
      send_request(hcbp_pkg::REQ_ENCODE, 8'h02, 16'hffff, 5'd31);
      send_request(hcbp_pkg::REQ_LOAD, 8'h03, 16'h5a5a, 5'd7);
      send_request(hcbp_pkg::REQ_ENCODE, 8'h03, 16'h0000, 5'd0);
      send_request(hcbp_pkg::REQ_ENCODE, 8'h03, 16'h0000, 5'd0);  // crosses a byte boundary
      send_request(hcbp_pkg::REQ_FLUSH, 8'h00, 16'h0000, 5'd0);
      send_request(hcbp_pkg::REQ_LOAD, 8'h04, 16'h0001, 5'd1);
      send_request(hcbp_pkg::REQ_ENCODE, 8'h04, 16'h0000, 5'd0);
      send_request(hcbp_pkg::REQ_ENCODE, 8'h02, 16'h0000, 5'd0);  // 17 bits, two bytes
      send_request(hcbp_pkg::REQ_FLUSH, 8'h00, 16'h0000, 5'd0);
      send_request(hcbp_pkg::REQ_LOAD, 8'h05, 16'haaaa, 5'd17);
      send_request(hcbp_pkg::REQ_LOAD, 8'h03, 16'h8000, 5'd16);   // overwrite an entry
      send_request(hcbp_pkg::REQ_ENCODE, 8'h03, 16'h0000, 5'd0);
      send_request(hcbp_pkg::REQ_ENCODE, 8'h05, 16'h0000, 5'd0);
      send_request(hcbp_pkg::REQ_FLUSH, 8'h00, 16'h0000, 5'd0);
      wait_drained();

      // random part, one idling profile per phase, drained in between
      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_idle[p];
         done_items = 0;
         while (done_items < ITEMS_PER_PHASE) begin
            send_random_request(counted);
            if (counted) done_items++;
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (packer.errors == 0 && packer.expected_bytes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/hcbp_pkg.sv
rtl/hcbp_table.sv
rtl/hcbp_packer.sv
rtl/huffman_code_bit_packer_top.sv
test/huffman_code_bit_packer_top_tb.sv
